[sv/qvr_pkg.sv]
// Shared constants and the rounding helper of the quaternion vector rotation core.
package qvr_pkg;

    localparam int FRAC_BITS_DEF = 14;
    localparam int GUARD         = 8;
    localparam int QW            = 16;
    localparam int VW            = 24;
    localparam logic signed [63:0] OUT_MAX = 64'sd8388607;
    localparam logic signed [63:0] OUT_MIN = -64'sd8388608;

    // Shift right by s with rounding half away from zero; s is at least one.
    function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] x, input int s);
        logic signed [63:0] h;
        logic signed [63:0] y;
        h = 64'sd1 <<< (s - 1);
        if (x[63]) begin
            h = h - 64'sd1;
        end
        y = x + h;
        return y >>> s;
    endfunction

endpackage

[sv/qvr_isqrt.sv]
// Pipelined integer square root, one root bit per register stage.
module qvr_isqrt #(
    parameter int LW = 25,
    parameter int SW = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_v,
    input  logic [2*LW-1:0]   i_rad,
    input  logic [SW-1:0]     i_side,
    output logic              o_v,
    output logic [LW-1:0]     o_root,
    output logic [SW-1:0]     o_side
);
    localparam int RADW = 2 * LW;
    localparam int RMW  = LW + 2;

    logic            r_v    [LW];
    logic [RADW-1:0] r_rad  [LW];
    logic [LW-1:0]   r_res  [LW];
    logic [RMW-1:0]  r_rem  [LW];
    logic [SW-1:0]   r_side [LW];

    genvar k;
    for (k = 0; k < LW; k++) begin : g_step
        logic            p_v;
        logic [RADW-1:0] p_rad;
        logic [LW-1:0]   p_res;
        logic [RMW-1:0]  p_rem;
        logic [SW-1:0]   p_side;
        logic [RMW+1:0]  cur;
        logic [RMW+1:0]  trial;
        logic [RMW+1:0]  diff;
        logic [RMW-1:0]  n_rem;
        logic [LW-1:0]   n_res;

        if (k == 0) begin : g_first
            assign p_v    = i_v;
            assign p_rad  = i_rad;
            assign p_res  = '0;
            assign p_rem  = '0;
            assign p_side = i_side;
        end else begin : g_next
            assign p_v    = r_v[k-1];
            assign p_rad  = r_rad[k-1];
            assign p_res  = r_res[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_side = r_side[k-1];
        end

        always_comb begin
            cur   = {p_rem, p_rad[RADW-1 -: 2]};
            trial = {2'b00, p_res, 2'b01};
            diff  = cur - trial;
            if (cur >= trial) begin
                n_rem = diff[RMW-1:0];
                n_res = {p_res[LW-2:0], 1'b1};
            end else begin
                n_rem = cur[RMW-1:0];
                n_res = {p_res[LW-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k]  <= p_rad << 2;
                r_res[k]  <= n_res;
                r_rem[k]  <= n_rem;
                r_side[k] <= p_side;
            end
        end
    end

    assign o_v    = r_v[LW-1];
    assign o_root = r_res[LW-1];
    assign o_side = r_side[LW-1];

endmodule

[sv/qvr_div.sv]
// Four-lane pipelined restoring divider with a shared divisor, one quotient bit per stage.
module qvr_div #(
    parameter int NW = 40,
    parameter int DW = 26,
    parameter int QB = 16,
    parameter int SW = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_v,
    input  logic [3:0][NW-1:0]    i_num,
    input  logic [DW-1:0]         i_den,
    input  logic [SW-1:0]         i_side,
    output logic                  o_v,
    output logic [3:0][QB-1:0]    o_quot,
    output logic [SW-1:0]         o_side
);
    localparam int CW = DW + QB;

    logic                r_v    [QB];
    logic [DW-1:0]       r_den  [QB];
    logic [3:0][CW-1:0]  r_rem  [QB];
    logic [3:0][QB-1:0]  r_quot [QB];
    logic [SW-1:0]       r_side [QB];

    genvar k;
    for (k = 0; k < QB; k++) begin : g_step
        localparam int B = QB - 1 - k;
        logic               p_v;
        logic [DW-1:0]      p_den;
        logic [3:0][CW-1:0] p_rem;
        logic [3:0][QB-1:0] p_quot;
        logic [SW-1:0]      p_side;
        logic [CW-1:0]      dsh;
        logic [3:0][CW-1:0] n_rem;
        logic [3:0][QB-1:0] n_quot;

        if (k == 0) begin : g_first
            assign p_v    = i_v;
            assign p_den  = i_den;
            assign p_quot = '0;
            assign p_side = i_side;
            for (genvar l = 0; l < 4; l++) begin : g_ext
                assign p_rem[l] = CW'(i_num[l]);
            end
        end else begin : g_next
            assign p_v    = r_v[k-1];
            assign p_den  = r_den[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_quot = r_quot[k-1];
            assign p_side = r_side[k-1];
        end

        always_comb begin
            dsh = {{QB{1'b0}}, p_den} << B;
            for (int l = 0; l < 4; l++) begin
                if (p_rem[l] >= dsh) begin
                    n_rem[l]  = p_rem[l] - dsh;
                    n_quot[l] = p_quot[l] | (QB'(1) << B);
                end else begin
                    n_rem[l]  = p_rem[l];
                    n_quot[l] = p_quot[l];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[k]  <= p_den;
                r_rem[k]  <= n_rem;
                r_quot[k] <= n_quot;
                r_side[k] <= p_side;
            end
        end
    end

    assign o_v    = r_v[QB-1];
    assign o_quot = r_quot[QB-1];
    assign o_side = r_side[QB-1];

endmodule

[sv/quaternion_vector_rotate_core.sv]
// Top level of the quaternion vector rotation core.
//
// Each item carries a quaternion q (signed, FRAC_BITS fraction bits) and a
// vector v; the core returns the vector part of q * (v * inv(q)), where the
// inverse is the conjugate of q divided by its length, so for a non-unit q the
// result is scaled by the length of q. Components are rounded half away from
// zero and saturated to 24 bits, with o_clipped set when any of them clamps.
// An all-zero quaternion gives a zero vector with o_zero_quat set. The core
// takes one item per cycle while o_stall is low and delivers one result per
// cycle while i_stall is low. Items pass through the square root, which
// resolves one root bit per stage over 25 stages, and through the four-lane
// divider, which resolves one quotient bit per stage over FRAC_BITS + 2
// stages; the remaining stages square, sum, normalize and perform the two
// Hamilton products with a register after each multiply.
// A two-entry output buffer lets the core accept one more item while a
// result waits on a stalled consumer; o_stall rises only when both entries
// are full.
module quaternion_vector_rotate_core #(
    parameter int FRAC_BITS = qvr_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic signed [qvr_pkg::QW-1:0]    i_quat_w,
    input  logic signed [qvr_pkg::QW-1:0]    i_quat_x,
    input  logic signed [qvr_pkg::QW-1:0]    i_quat_y,
    input  logic signed [qvr_pkg::QW-1:0]    i_quat_z,
    input  logic signed [qvr_pkg::VW-1:0]    i_vec_x,
    input  logic signed [qvr_pkg::VW-1:0]    i_vec_y,
    input  logic signed [qvr_pkg::VW-1:0]    i_vec_z,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic signed [qvr_pkg::VW-1:0]    o_rot_x,
    output logic signed [qvr_pkg::VW-1:0]    o_rot_y,
    output logic signed [qvr_pkg::VW-1:0]    o_rot_z,
    output logic                             o_clipped,
    output logic                             o_zero_quat
);
    import qvr_pkg::*;

    // Sum of squares is below 2^33; the root covers it with the guard bits.
    localparam int SQ1W = 2 * QW - 1;
    localparam int SQW  = 2 * QW + 1;
    localparam int LW   = (SQW + 2 * GUARD + 1) / 2;
    localparam int RADW = 2 * LW;
    localparam int DW   = LW + 1;
    localparam int NW   = QW + FRAC_BITS + GUARD + 2;
    localparam int QB   = FRAC_BITS + 2;
    localparam int NB   = FRAC_BITS + 3;
    localparam int PW   = VW + NB;
    localparam int TW   = 28;
    localparam int MW   = QW + TW;
    localparam int SW   = 4 * QW + 3 * VW + 1;

    // The whole pipeline holds while the skid entry is occupied.
    logic r_skid_v;
    logic en;
    assign en      = !r_skid_v;
    assign o_stall = !en;

    // Stage 1: squares of the quaternion components.
    logic                 r1_v;
    logic signed [QW-1:0] r1_q [4];
    logic signed [VW-1:0] r1_vec [3];
    logic [SQ1W-1:0]      r1_sq [4];
    logic signed [2*QW-1:0] sq [4];

    always_comb begin
        sq[0] = i_quat_w * i_quat_w;
        sq[1] = i_quat_x * i_quat_x;
        sq[2] = i_quat_y * i_quat_y;
        sq[3] = i_quat_z * i_quat_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_q[0]   <= i_quat_w;
            r1_q[1]   <= i_quat_x;
            r1_q[2]   <= i_quat_y;
            r1_q[3]   <= i_quat_z;
            r1_vec[0] <= i_vec_x;
            r1_vec[1] <= i_vec_y;
            r1_vec[2] <= i_vec_z;
            for (int c = 0; c < 4; c++) begin
                r1_sq[c] <= sq[c][SQ1W-1:0];
            end
        end
    end

    // Stage 2: squared length and zero detect.
    logic                 r2_v;
    logic signed [QW-1:0] r2_q [4];
    logic signed [VW-1:0] r2_vec [3];
    logic [SQW-1:0]       r2_s;
    logic [SQW-1:0]       n_s;

    assign n_s = SQW'(r1_sq[0]) + SQW'(r1_sq[1]) + SQW'(r1_sq[2]) + SQW'(r1_sq[3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_q   <= r1_q;
            r2_vec <= r1_vec;
            r2_s   <= n_s;
        end
    end

    logic [RADW-1:0] rad;
    logic [SW-1:0]   side2;
    assign rad   = {{(RADW - SQW - 2 * GUARD){1'b0}}, r2_s, {(2 * GUARD){1'b0}}};
    assign side2 = {r2_q[0], r2_q[1], r2_q[2], r2_q[3],
                    r2_vec[0], r2_vec[1], r2_vec[2], (r2_s == '0)};

    logic            s3_v;
    logic [LW-1:0]   s3_len;
    logic [SW-1:0]   s3_side;

    qvr_isqrt #(.LW(LW), .SW(SW)) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_v     (r2_v),
        .i_rad   (rad),
        .i_side  (side2),
        .o_v     (s3_v),
        .o_root  (s3_len),
        .o_side  (s3_side)
    );

    // Stage 3: rounded-division operands, 2|q| << (F+G) plus the length over twice the length.
    logic signed [QW-1:0] u3_q [4];
    logic [QW-1:0]        mag3 [4];

    always_comb begin
        u3_q[0] = s3_side[SW-1 -: QW];
        u3_q[1] = s3_side[SW-1-QW -: QW];
        u3_q[2] = s3_side[SW-1-2*QW -: QW];
        u3_q[3] = s3_side[SW-1-3*QW -: QW];
        for (int c = 0; c < 4; c++) begin
            mag3[c] = u3_q[c][QW-1] ? (~u3_q[c] + 1'b1) : u3_q[c];
        end
    end

    logic                r3_v;
    logic [3:0][NW-1:0]  r3_num;
    logic [DW-1:0]       r3_den;
    logic [SW-1:0]       r3_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < 4; c++) begin
                r3_num[c] <= {1'b0, mag3[c], {(FRAC_BITS + GUARD + 1){1'b0}}} + NW'(s3_len);
            end
            r3_den  <= {s3_len, 1'b0};
            r3_side <= s3_side;
        end
    end

    logic                s4_v;
    logic [3:0][QB-1:0]  s4_quot;
    logic [SW-1:0]       s4_side;

    qvr_div #(.NW(NW), .DW(DW), .QB(QB), .SW(SW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_v     (r3_v),
        .i_num   (r3_num),
        .i_den   (r3_den),
        .i_side  (r3_side),
        .o_v     (s4_v),
        .o_quot  (s4_quot),
        .o_side  (s4_side)
    );

    // Stage 4: signed inverse, the conjugate of the normalized quaternion.
    logic signed [QW-1:0] u4_q [4];
    logic signed [VW-1:0] u4_vec [3];
    logic signed [NB-1:0] mag4 [4];

    always_comb begin
        u4_q[0]   = s4_side[SW-1 -: QW];
        u4_q[1]   = s4_side[SW-1-QW -: QW];
        u4_q[2]   = s4_side[SW-1-2*QW -: QW];
        u4_q[3]   = s4_side[SW-1-3*QW -: QW];
        u4_vec[0] = s4_side[3*VW -: VW];
        u4_vec[1] = s4_side[2*VW -: VW];
        u4_vec[2] = s4_side[VW -: VW];
        for (int c = 0; c < 4; c++) begin
            mag4[c] = {1'b0, s4_quot[c]};
        end
    end

    logic                 r4_v;
    logic                 r4_zero;
    logic signed [QW-1:0] r4_q [4];
    logic signed [VW-1:0] r4_vec [3];
    logic signed [NB-1:0] r4_n [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (en) begin
            r4_v <= s4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_q    <= u4_q;
            r4_vec  <= u4_vec;
            r4_zero <= s4_side[0];
            r4_n[0] <= u4_q[0][QW-1] ? -mag4[0] : mag4[0];
            for (int c = 1; c < 4; c++) begin
                r4_n[c] <= u4_q[c][QW-1] ? mag4[c] : -mag4[c];
            end
        end
    end

    // Stage 5: products of the vector with the inverse.
    logic                 r5_v;
    logic                 r5_zero;
    logic signed [QW-1:0] r5_q [4];
    logic signed [PW-1:0] r5_p [12];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (en) begin
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_q     <= r4_q;
            r5_zero  <= r4_zero;
            r5_p[0]  <= r4_vec[0] * r4_n[1];
            r5_p[1]  <= r4_vec[1] * r4_n[2];
            r5_p[2]  <= r4_vec[2] * r4_n[3];
            r5_p[3]  <= r4_vec[0] * r4_n[0];
            r5_p[4]  <= r4_vec[1] * r4_n[3];
            r5_p[5]  <= r4_vec[2] * r4_n[2];
            r5_p[6]  <= r4_vec[1] * r4_n[0];
            r5_p[7]  <= r4_vec[2] * r4_n[1];
            r5_p[8]  <= r4_vec[0] * r4_n[3];
            r5_p[9]  <= r4_vec[2] * r4_n[0];
            r5_p[10] <= r4_vec[0] * r4_n[2];
            r5_p[11] <= r4_vec[1] * r4_n[1];
        end
    end

    // Stage 6: the intermediate quaternion t = (0, v) * inv, rounded.
    logic signed [63:0] e5 [12];
    logic signed [63:0] t6 [4];

    always_comb begin
        for (int c = 0; c < 12; c++) begin
            e5[c] = r5_p[c];
        end
        t6[0] = rnd_shr(-e5[0] - e5[1] - e5[2], FRAC_BITS);
        t6[1] = rnd_shr(e5[3] + e5[4] - e5[5], FRAC_BITS);
        t6[2] = rnd_shr(e5[6] + e5[7] - e5[8], FRAC_BITS);
        t6[3] = rnd_shr(e5[9] + e5[10] - e5[11], FRAC_BITS);
    end

    logic                 r6_v;
    logic                 r6_zero;
    logic signed [QW-1:0] r6_q [4];
    logic signed [TW-1:0] r6_t [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (en) begin
            r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_q    <= r5_q;
            r6_zero <= r5_zero;
            for (int c = 0; c < 4; c++) begin
                r6_t[c] <= t6[c][TW-1:0];
            end
        end
    end

    // Stage 7: products of q with t.
    logic                 r7_v;
    logic                 r7_zero;
    logic signed [MW-1:0] r7_m [12];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else if (en) begin
            r7_v <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_zero  <= r6_zero;
            r7_m[0]  <= r6_q[0] * r6_t[1];
            r7_m[1]  <= r6_q[1] * r6_t[0];
            r7_m[2]  <= r6_q[2] * r6_t[3];
            r7_m[3]  <= r6_q[3] * r6_t[2];
            r7_m[4]  <= r6_q[0] * r6_t[2];
            r7_m[5]  <= r6_q[2] * r6_t[0];
            r7_m[6]  <= r6_q[3] * r6_t[1];
            r7_m[7]  <= r6_q[1] * r6_t[3];
            r7_m[8]  <= r6_q[0] * r6_t[3];
            r7_m[9]  <= r6_q[3] * r6_t[0];
            r7_m[10] <= r6_q[1] * r6_t[2];
            r7_m[11] <= r6_q[2] * r6_t[1];
        end
    end

    // Final sums, rounding and saturation feed the output buffer directly.
    logic signed [63:0] e7 [12];
    logic signed [63:0] r8 [3];
    logic signed [VW-1:0] p_rot [3];
    logic                 p_clip;

    always_comb begin
        for (int c = 0; c < 12; c++) begin
            e7[c] = r7_m[c];
        end
        r8[0]  = rnd_shr(e7[0] + e7[1] + e7[2] - e7[3], FRAC_BITS);
        r8[1]  = rnd_shr(e7[4] + e7[5] + e7[6] - e7[7], FRAC_BITS);
        r8[2]  = rnd_shr(e7[8] + e7[9] + e7[10] - e7[11], FRAC_BITS);
        p_clip = 1'b0;
        for (int c = 0; c < 3; c++) begin
            if (r8[c] > OUT_MAX) begin
                p_rot[c] = OUT_MAX[VW-1:0];
                p_clip   = 1'b1;
            end else if (r8[c] < OUT_MIN) begin
                p_rot[c] = OUT_MIN[VW-1:0];
                p_clip   = 1'b1;
            end else begin
                p_rot[c] = r8[c][VW-1:0];
            end
            if (r7_zero) begin
                p_rot[c] = '0;
            end
        end
        if (r7_zero) begin
            p_clip = 1'b0;
        end
    end

    // Output register plus one skid entry.
    logic                 r_out_v;
    logic signed [VW-1:0] r_out_rot [3];
    logic                 r_out_clip;
    logic                 r_out_zero;
    logic signed [VW-1:0] r_skid_rot [3];
    logic                 r_skid_clip;
    logic                 r_skid_zero;
    logic                 take;

    assign take = !r_out_v || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (take) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= r7_v;
            end
        end else if (en && r7_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            if (r_skid_v) begin
                r_out_rot  <= r_skid_rot;
                r_out_clip <= r_skid_clip;
                r_out_zero <= r_skid_zero;
            end else begin
                r_out_rot  <= p_rot;
                r_out_clip <= p_clip;
                r_out_zero <= r7_zero;
            end
        end else if (en) begin
            r_skid_rot  <= p_rot;
            r_skid_clip <= p_clip;
            r_skid_zero <= r7_zero;
        end
    end

    assign o_valid     = r_out_v;
    assign o_rot_x     = r_out_rot[0];
    assign o_rot_y     = r_out_rot[1];
    assign o_rot_z     = r_out_rot[2];
    assign o_clipped   = r_out_clip;
    assign o_zero_quat = r_out_zero;

endmodule
